FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: design/dasm_pkg.sv
// ---------------------------------------------------------------------------
// Decimal ALU package
// Shared types and constants of the decimal add/subtract/multiply unit.
// ---------------------------------------------------------------------------
package dasm_pkg;
  localparam int MB = 32;
  localparam int EB = 7;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_BAD = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    K_ADD,
    K_MUL,
    K_OVF
  } kind_e;

  typedef struct packed {
    kind_e         kind;
    logic          ls;
    logic [MB-1:0] lm;
    logic [EB-1:0] le;
    logic          rs;
    logic [MB-1:0] rm;
    logic [EB-1:0] re;
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALIGN,
    S_SUM,
    S_LOGL,
    S_LOGR,
    S_CHK,
    S_MUL,
    S_MODC,
    S_CMP,
    S_OUT
  } state_e;

  localparam logic [EB-1:0] OVF_EXP = 7'h7F;
endpackage

FILE: design/dasm_front.sv
// ---------------------------------------------------------------------------
// Decimal ALU front end
// Accepts requests, classifies them and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module dasm_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             req_type_i,
  input  logic                   left_sign_i,
  input  logic [31:0]            left_mantissa_i,
  input  logic [6:0]             left_exponent_i,
  input  logic                   right_sign_i,
  input  logic [31:0]            right_mantissa_i,
  input  logic [6:0]             right_exponent_i,
  output logic                   job_valid_o,
  input  logic                   job_ready_i,
  output dasm_pkg::job_t         job_o
);
  import dasm_pkg::*;
  `include "assert_macros.svh"

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  job_t       job_d;
  logic       push, pop;

  always_comb begin
    job_d.ls = left_sign_i;
    job_d.lm = left_mantissa_i;
    job_d.le = left_exponent_i;
    job_d.rs = right_sign_i ^ (req_type_i == OP_SUB);
    job_d.rm = right_mantissa_i;
    job_d.re = right_exponent_i;
    unique case (op_e'(req_type_i)) inside
      OP_ADD, OP_SUB: job_d.kind = K_ADD;
      OP_MUL:         job_d.kind = K_MUL;
      default:        job_d.kind = K_OVF;
    endcase
  end

  assign in_ready    = (cnt_q != 2'd2);
  assign push        = in_valid && in_ready;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  `ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q == 2'd3)
  `ASSERT_PROP(a_ptr_cnt, clk_i, rst_ni, (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q)
  `ASSERT_PROP(a_cnt_step, clk_i, rst_ni, (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1)
endmodule

FILE: design/dasm_back.sv
// ---------------------------------------------------------------------------
// Decimal ALU back end
// Sequencer that aligns, adds, checks, multiplies and compacts one job.
// ---------------------------------------------------------------------------
module dasm_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [6:0]             ovf_bits_i,
  input  logic                   job_valid_i,
  output logic                   job_ready_o,
  input  dasm_pkg::job_t         job_i,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   result_sign_o,
  output logic [31:0]            result_mantissa_o,
  output logic [6:0]             result_exponent_o
);
  import dasm_pkg::*;
  `include "assert_macros.svh"

  // ceil(2^35 / 10), exact quotient by ten for 32-bit operands
  localparam logic [MB-1:0] RECIP10 = 32'hCCCCCCCD;

  state_e        st_q, st_d;
  job_t          j_q;
  logic [MB-1:0] a_q;
  logic [EB-1:0] cnt_q, e_q;
  logic [6:0]    sum_q;
  logic [MB-1:0] pl_q;
  logic          s_q;
  logic [MB-1:0] m_q;
  logic [EB-1:0] x_q;
  logic [2*MB-1:0] rq;
  logic [MB-1:0] q10;
  logic [3:0]    r10;
  logic [MB-1:0] prod;
  logic [MB-1:0] ld, rd;
  logic [6:0]    lgv;

  // quotient and remainder of a_q by ten
  assign rq  = a_q * RECIP10;
  assign q10 = {3'b000, rq[2*MB-1:MB+3]};
  assign r10 = a_q[3:0] - {q10[0], 3'b000} - {q10[2:0], 1'b0};

  always_comb begin
    lgv = 7'd0;
    for (int i = 1; i < MB; i++) if (a_q[i]) lgv = 7'(i);
  end

  assign prod = j_q.lm * j_q.rm;
  assign ld   = (j_q.le > j_q.re) ? j_q.lm : a_q;
  assign rd   = (j_q.le > j_q.re) ? a_q : j_q.rm;

  always_comb begin
    st_d        = st_q;
    job_ready_o = 1'b0;
    out_valid   = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          unique case (job_i.kind)
            K_ADD:   st_d = S_ALIGN;
            K_MUL:   st_d = S_LOGL;
            default: st_d = S_OUT;
          endcase
        end
      end
      S_ALIGN: if (cnt_q == '0) st_d = S_SUM;
      S_SUM:   st_d = S_OUT;
      S_LOGL:  if (cnt_q == '0 || a_q == '0) st_d = S_LOGR;
      S_LOGR:  if (cnt_q == '0 || a_q == '0) st_d = S_CHK;
      S_CHK:   st_d = (sum_q > ovf_bits_i) ? S_OUT : S_MUL;
      S_MUL:   st_d = S_MODC;
      S_MODC:  st_d = (r10 == 4'd0 && e_q != '0) ? S_CMP : S_OUT;
      S_CMP:   st_d = (r10 == 4'd0) ? S_MODC : S_OUT;
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= S_IDLE;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: if (job_valid_i) begin
        j_q <= job_i;
        s_q <= 1'b0; m_q <= '0; x_q <= OVF_EXP;
        if (job_i.kind == K_ADD) begin
          a_q   <= (job_i.le > job_i.re) ? job_i.rm : job_i.lm;
          cnt_q <= (job_i.le > job_i.re) ? job_i.le - job_i.re : job_i.re - job_i.le;
        end else begin
          a_q   <= job_i.lm;
          cnt_q <= job_i.le;
        end
      end
      S_ALIGN: if (cnt_q != '0) begin
        a_q   <= {a_q[MB-4:0], 3'b000} + {a_q[MB-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
      end
      S_SUM: begin
        x_q <= (j_q.le > j_q.re) ? j_q.le : j_q.re;
        if (j_q.ls == j_q.rs) begin
          s_q <= j_q.ls; m_q <= ld + rd;
        end else if (ld > rd) begin
          s_q <= j_q.ls; m_q <= ld - rd;
        end else if (rd > ld) begin
          s_q <= j_q.rs; m_q <= rd - ld;
        end else begin
          s_q <= 1'b0; m_q <= '0;
        end
      end
      S_LOGL: begin
        if (cnt_q == '0 || a_q == '0) begin
          sum_q <= lgv;
          a_q   <= j_q.rm;
          cnt_q <= j_q.re;
        end else begin
          a_q <= q10; cnt_q <= cnt_q - 1'b1;
        end
      end
      S_LOGR: begin
        if (cnt_q == '0 || a_q == '0) sum_q <= sum_q + lgv;
        else begin
          a_q <= q10; cnt_q <= cnt_q - 1'b1;
        end
      end
      S_MUL: begin
        pl_q <= prod;
        a_q  <= prod;
        e_q  <= j_q.le + j_q.re;
        s_q  <= j_q.ls ^ j_q.rs;
      end
      // a_q holds the mantissa: check the units digit
      S_MODC: begin
        m_q <= pl_q;
        x_q <= e_q;
        a_q <= q10;
      end
      // a_q holds mantissa / 10: check the tens digit
      S_CMP: if (r10 == 4'd0) begin
        pl_q <= a_q;
        e_q  <= e_q - 1'b1;
      end
      default: ;
    endcase
  end

  assign result_sign_o     = s_q;
  assign result_mantissa_o = m_q;
  assign result_exponent_o = x_q;

  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, (out_valid && !out_ready) |=> out_valid)
  `ASSERT_PROP(a_take_idle, clk_i, rst_ni, job_ready_o |-> st_q == S_IDLE)
  `ASSERT_NEVER(a_both, clk_i, rst_ni, job_ready_o && out_valid)
endmodule

FILE: design/decimal_add_sub_mul_unit.sv
// ---------------------------------------------------------------------------
// Decimal add/subtract/multiply unit
// Sign-magnitude scaled-integer decimal ALU.
// ---------------------------------------------------------------------------
// Usage: a request transfers on in_valid/in_ready with op code and two
// operands (sign, mantissa, decimal exponent). One result transfers per
// request on out_valid/out_ready, in request order.
// A two-entry queue lets the front take requests while the back works.
// Sequence with the back idle: add/subtract scale the operand with the
// smaller exponent by repeated x10 steps (one x10 step per cycle), then
// add. Multiply runs the integer-part divide-by-ten loops on both operands
// (each loop ends early once the value reaches zero), checks for overflow,
// multiplies, then compacts: each compaction step checks the units digit
// and, when it is zero and the exponent nonzero, the tens digit. A multiply
// overflow answers without the multiply path; an unused op code answers directly.
// Throughput is one job at a time in the back sequencer, which takes the
// next job the cycle after a result transfers.
// The user must write overflow_bits (reset 31) only while idle; the block
// does not enforce it. Reset clears the queue and the sequencer. A stalled
// receiver holds the result; the front keeps accepting until the queue is full.
// ---------------------------------------------------------------------------
module decimal_add_sub_mul_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data_i,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type_i,
  input  logic        left_sign_i,
  input  logic [31:0] left_mantissa_i,
  input  logic [6:0]  left_exponent_i,
  input  logic        right_sign_i,
  input  logic [31:0] right_mantissa_i,
  input  logic [6:0]  right_exponent_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_sign_o,
  output logic [31:0] result_mantissa_o,
  output logic [6:0]  result_exponent_o
);
  import dasm_pkg::*;

  logic [6:0] ovf_q;
  logic       jv, jr;
  job_t       job;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovf_q <= 7'd31;
    else if (cfg_valid) ovf_q <= cfg_data_i;
  end

  dasm_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .req_type_i, .left_sign_i,
    .left_mantissa_i, .left_exponent_i, .right_sign_i, .right_mantissa_i,
    .right_exponent_i, .job_valid_o(jv), .job_ready_i(jr), .job_o(job)
  );

  dasm_back u_back (
    .clk_i, .rst_ni, .ovf_bits_i(ovf_q), .job_valid_i(jv), .job_ready_o(jr),
    .job_i(job), .out_valid, .out_ready, .result_sign_o, .result_mantissa_o,
    .result_exponent_o
  );
endmodule
